### hw/rtl/pcfd_pkg.sv
package pcfd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_W    = FRAC_BITS + 1;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SMOOTH_FACTOR = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT      = 3'd6;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_INTEG,
        MUL_ALPHA,
        MUL_BETA,
        MUL_PROP,
        MUL_DERIV
    } mul_sel_t;

    // What the accumulate stage does with the scaled product
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_INTEG,
        ACC_HOLD,
        ACC_FILT,
        ACC_PSUM,
        ACC_DRIVE
    } acc_op_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     q_en;
        acc_op_t  acc_op;
    } cmd_t;

endpackage

### hw/rtl/pcfd_sample_if.sv
interface pcfd_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pcfd_pkg::DATA_WIDTH-1:0]  measured;

    modport source (output valid, output measured, input ready);
    modport sink (input valid, input measured, output ready);
endinterface

### hw/rtl/pcfd_result_if.sv
interface pcfd_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [pcfd_pkg::DATA_WIDTH-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

### hw/rtl/pcfd_ctrl.sv
module pcfd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_ready,
    output logic            result_valid,
    input  logic            result_ready,
    output pcfd_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_I,
        ST_A,
        ST_B,
        ST_P,
        ST_GAP,
        ST_D,
        ST_TAIL,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   slot_free;

    assign slot_free    = !result_valid_reg || result_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg && !result_ready;
        cmd.load          = 1'b0;
        cmd.mul_sel       = pcfd_pkg::MUL_INTEG;
        cmd.q_en          = 1'b1;
        cmd.acc_op        = pcfd_pkg::ACC_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.q_en = 1'b0;
                cmd.load = sample_valid;
                if (sample_valid)
                begin
                    state_next = ST_I;
                end
            end
            ST_I:
            begin
                state_next = ST_A;
            end
            ST_A:
            begin
                cmd.mul_sel = pcfd_pkg::MUL_ALPHA;
                state_next  = ST_B;
            end
            ST_B:
            begin
                cmd.mul_sel = pcfd_pkg::MUL_BETA;
                cmd.acc_op  = pcfd_pkg::ACC_INTEG;
                state_next  = ST_P;
            end
            ST_P:
            begin
                cmd.mul_sel = pcfd_pkg::MUL_PROP;
                cmd.acc_op  = pcfd_pkg::ACC_HOLD;
                state_next  = ST_GAP;
            end
            ST_GAP:
            begin
                // derivative product waits for the new filtered slope
                cmd.mul_sel = pcfd_pkg::MUL_DERIV;
                cmd.acc_op  = pcfd_pkg::ACC_FILT;
                state_next  = ST_D;
            end
            ST_D:
            begin
                cmd.mul_sel = pcfd_pkg::MUL_DERIV;
                cmd.acc_op  = pcfd_pkg::ACC_PSUM;
                state_next  = ST_TAIL;
            end
            ST_TAIL:
            begin
                cmd.mul_sel = pcfd_pkg::MUL_DERIV;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output slot is free
                cmd.mul_sel = pcfd_pkg::MUL_DERIV;
                cmd.q_en    = 1'b0;
                if (slot_free)
                begin
                    cmd.acc_op        = pcfd_pkg::ACC_DRIVE;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_drive_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_op == pcfd_pkg::ACC_DRIVE |-> (!result_valid_reg || result_ready))
        else $error("result overwritten before it was taken");

    a_drive_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_op == pcfd_pkg::ACC_DRIVE |=> result_valid_reg)
        else $error("finished result not presented");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second request accepted while one is in work");
`endif

endmodule

### hw/rtl/pcfd_datapath.sv
module pcfd_datapath
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  pcfd_pkg::cmd_t                            cmd,
    input  logic signed [pcfd_pkg::DATA_WIDTH-1:0]    measured,
    input  logic                                      wr_en,
    input  logic [pcfd_pkg::REG_IDX_W-1:0]            wr_index,
    input  logic [pcfd_pkg::DATA_WIDTH-1:0]           wr_data,
    output logic signed [pcfd_pkg::DATA_WIDTH-1:0]    drive
);

    localparam int DW = pcfd_pkg::DATA_WIDTH;
    localparam int FB = pcfd_pkg::FRAC_BITS;
    localparam int AW = pcfd_pkg::ALPHA_W;
    localparam logic [AW-1:0] ONE_Q = {1'b1, {FB{1'b0}}};

    // saturate a two-bit-wider sum to DW bits
    function automatic logic signed [DW-1:0] sat_w(input logic signed [DW+1:0] v);
        logic fits;
        fits = (&v[DW+1:DW-1]) || !(|v[DW+1:DW-1]);
        if (fits)
        begin
            sat_w = v[DW-1:0];
        end
        else
        begin
            sat_w = {v[DW+1], {(DW-1){!v[DW+1]}}};
        end
    endfunction

    // hi is tested first; inverted limits give hi if v > hi, else lo
    function automatic logic signed [DW-1:0] clamp_w(
        input logic signed [DW-1:0] v,
        input logic signed [DW-1:0] lo,
        input logic signed [DW-1:0] hi
    );
        priority if (v > hi)
        begin
            clamp_w = hi;
        end
        else if (v < lo)
        begin
            clamp_w = lo;
        end
        else
        begin
            clamp_w = v;
        end
    endfunction

    logic signed [DW-1:0] prop_gain_reg;
    logic signed [DW-1:0] integ_gain_reg;
    logic signed [DW-1:0] deriv_gain_reg;
    logic [AW-1:0]        smooth_factor_reg;
    logic signed [DW-1:0] drive_min_reg;
    logic signed [DW-1:0] drive_max_reg;
    logic signed [DW-1:0] setpoint_reg;

    logic signed [DW-1:0] integral_reg;
    logic signed [DW-1:0] filt_reg;
    logic signed [DW-1:0] prev_reg;

    logic signed [DW-1:0] meas_reg;
    logic signed [DW-1:0] err_reg;
    logic signed [DW-1:0] slope_reg;
    logic signed [2*DW:0] prod_reg;
    logic signed [DW-1:0] q_reg;
    logic signed [DW-1:0] hold_reg;
    logic signed [DW:0]   psum_reg;
    logic signed [DW-1:0] drive_reg;

    logic [AW-1:0]        alpha;
    logic [AW-1:0]        beta;
    logic signed [DW:0]   mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [2*DW:0] prod_next;
    logic signed [2*DW:0] biased;
    logic signed [2*DW:0] shifted;
    logic signed [DW-1:0] q_next;
    logic signed [DW-1:0] err_next;
    logic signed [DW-1:0] slope_next;
    logic signed [DW-1:0] integral_next;
    logic signed [DW-1:0] filt_next;
    logic signed [DW:0]   psum_next;
    logic signed [DW-1:0] drive_next;

    assign alpha = (smooth_factor_reg > ONE_Q) ? ONE_Q : smooth_factor_reg;
    assign beta  = ONE_Q - alpha;

    always_comb
    begin
        unique case (cmd.mul_sel)
            pcfd_pkg::MUL_INTEG:
            begin
                mul_a = {integ_gain_reg[DW-1], integ_gain_reg};
                mul_b = err_reg;
            end
            pcfd_pkg::MUL_ALPHA:
            begin
                mul_a = {{(DW-FB){1'b0}}, alpha};
                mul_b = slope_reg;
            end
            pcfd_pkg::MUL_BETA:
            begin
                mul_a = {{(DW-FB){1'b0}}, beta};
                mul_b = filt_reg;
            end
            pcfd_pkg::MUL_PROP:
            begin
                mul_a = {prop_gain_reg[DW-1], prop_gain_reg};
                mul_b = err_reg;
            end
            pcfd_pkg::MUL_DERIV:
            begin
                mul_a = {deriv_gain_reg[DW-1], deriv_gain_reg};
                mul_b = filt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // drop fraction bits toward zero, then saturate
    assign biased  = prod_reg + (prod_reg[2*DW] ? (2*DW+1)'({FB{1'b1}}) : '0);
    assign shifted = biased >>> FB;

    always_comb
    begin
        if ((&shifted[2*DW:DW-1]) || !(|shifted[2*DW:DW-1]))
        begin
            q_next = shifted[DW-1:0];
        end
        else
        begin
            q_next = {shifted[2*DW], {(DW-1){!shifted[2*DW]}}};
        end
    end

    assign err_next   = sat_w({{2{setpoint_reg[DW-1]}}, setpoint_reg}
                            - {{2{measured[DW-1]}}, measured});
    assign slope_next = sat_w({{2{prev_reg[DW-1]}}, prev_reg}
                            - {{2{measured[DW-1]}}, measured});

    assign integral_next = clamp_w(sat_w({{2{integral_reg[DW-1]}}, integral_reg}
                                       + {{2{q_reg[DW-1]}}, q_reg}),
                                   drive_min_reg, drive_max_reg);
    assign filt_next     = sat_w({{2{hold_reg[DW-1]}}, hold_reg}
                               + {{2{q_reg[DW-1]}}, q_reg});
    assign psum_next     = {q_reg[DW-1], q_reg} + {integral_reg[DW-1], integral_reg};
    assign drive_next    = clamp_w(sat_w({psum_reg[DW], psum_reg}
                                       + {{2{q_reg[DW-1]}}, q_reg}),
                                   drive_min_reg, drive_max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            smooth_factor_reg <= '0;
            drive_min_reg     <= '0;
            drive_max_reg     <= '0;
            setpoint_reg      <= '0;
            integral_reg      <= '0;
            filt_reg          <= '0;
            prev_reg          <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    pcfd_pkg::REG_PROP_GAIN:     prop_gain_reg     <= wr_data;
                    pcfd_pkg::REG_INTEG_GAIN:    integ_gain_reg    <= wr_data;
                    pcfd_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= wr_data;
                    pcfd_pkg::REG_SMOOTH_FACTOR: smooth_factor_reg <= wr_data[AW-1:0];
                    pcfd_pkg::REG_DRIVE_MIN:     drive_min_reg     <= wr_data;
                    pcfd_pkg::REG_DRIVE_MAX:     drive_max_reg     <= wr_data;
                    pcfd_pkg::REG_SETPOINT:      setpoint_reg      <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.acc_op == pcfd_pkg::ACC_INTEG)
            begin
                integral_reg <= integral_next;
            end
            if (cmd.acc_op == pcfd_pkg::ACC_FILT)
            begin
                filt_reg <= filt_next;
                prev_reg <= meas_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            meas_reg  <= measured;
            err_reg   <= err_next;
            slope_reg <= slope_next;
        end
        if (cmd.q_en)
        begin
            q_reg <= q_next;
        end
        if (cmd.acc_op == pcfd_pkg::ACC_HOLD)
        begin
            hold_reg <= q_reg;
        end
        if (cmd.acc_op == pcfd_pkg::ACC_PSUM)
        begin
            psum_reg <= psum_next;
        end
        if (cmd.acc_op == pcfd_pkg::ACC_DRIVE)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

`ifndef SYNTHESIS
    a_integral_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_op == pcfd_pkg::ACC_INTEG && drive_min_reg <= drive_max_reg
        |=> integral_reg >= drive_min_reg && integral_reg <= drive_max_reg)
        else $error("integral term outside limits");

    a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_op == pcfd_pkg::ACC_DRIVE && drive_min_reg <= drive_max_reg
        |=> drive_reg >= drive_min_reg && drive_reg <= drive_max_reg)
        else $error("drive outside limits");
`endif

endmodule

### hw/rtl/pid_clamped_filtered_derivative_unit.sv
// The block takes a new request only once the previous one is finished and its
// result moved to the output register; five products share one multiplier
// that feeds a scale-and-saturate stage and an accumulate stage.
// A result still waiting in the output register holds the last step only.
// Reset (rst_n, async, active low) zeroes the setting registers, integral, filter
// and previous sample; the block is ready right after reset.
module pid_clamped_filtered_derivative_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    pcfd_sample_if.sink                           sample,
    pcfd_result_if.source                         result,
    input  logic                                  wr_en,
    input  logic [pcfd_pkg::REG_IDX_W-1:0]        wr_index,
    input  logic [pcfd_pkg::DATA_WIDTH-1:0]       wr_data
);

    pcfd_pkg::cmd_t cmd;

    pcfd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    pcfd_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .measured (sample.measured),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .drive    (result.drive)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int W = pcfd_pkg::DATA_WIDTH;
    localparam logic [pcfd_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam longint SAT_HI = (64'sd1 <<< (W - 1)) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< (W - 1));
    localparam longint UNITY = 64'sd1 <<< pcfd_pkg::FRAC_BITS;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE = 24;

    typedef enum int {VAL_ANY, VAL_CORNER, VAL_NEAR} val_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    logic [W-1:0] drv_meas = '0;
    logic rcv_ready = 1'b0;
    logic wr_en = 1'b0;
    logic [pcfd_pkg::REG_IDX_W-1:0] wr_index = '0;
    logic [W-1:0] wr_data = '0;

    pcfd_sample_if sample_ch();
    pcfd_result_if result_ch();

    assign sample_ch.valid = drv_valid;
    assign sample_ch.measured = drv_meas;
    assign result_ch.ready = rcv_ready;

    pid_clamped_filtered_derivative_unit DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    // controller settings and loop state as the block should hold them
    longint kp = 0, ki = 0, kd = 0, alpha_raw = 0;
    longint lim_lo = 0, lim_hi = 0, target = 0;
    longint integ_acc = 0, slope_filt = 0, last_meas = 0;

    logic [W-1:0] sample_queue[$];
    logic [W-1:0] drive_queue[$];
    int queued_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int fail_count = 0;
    int settings_count = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int cycle_count = 0;

    function automatic longint sat_w(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // truncate toward zero, then saturate
    function automatic longint qmul(longint a, longint b);
        longint prod;
        longint mag;
        prod = a * b;
        mag = (prod < 0) ? -prod : prod;
        mag = mag >>> pcfd_pkg::FRAC_BITS;
        return sat_w((prod < 0) ? -mag : mag);
    endfunction

    // inverted limits: lim_hi for values above it, lim_lo for all others
    function automatic longint clamp_lim(longint v);
        if (v > lim_hi) return lim_hi;
        if (v < lim_lo) return lim_lo;
        return v;
    endfunction

    function automatic logic [W-1:0] next_drive(logic [W-1:0] sample_bits);
        longint meas, err, alpha, slope, p_term, d_term;
        meas = longint'($signed(sample_bits));
        err = sat_w(target - meas);
        alpha = (alpha_raw > UNITY) ? UNITY : alpha_raw;
        integ_acc = clamp_lim(sat_w(integ_acc + qmul(ki, err)));
        slope = sat_w(last_meas - meas);
        slope_filt = sat_w(qmul(alpha, slope) + qmul(UNITY - alpha, slope_filt));
        last_meas = meas;
        p_term = qmul(kp, err);
        d_term = qmul(kd, slope_filt);
        return W'(clamp_lim(sat_w(p_term + integ_acc + d_term)));
    endfunction

    function automatic logic [W-1:0] pick_word(val_kind_t kind);
        case (kind)
            VAL_CORNER:
            begin
                case ($urandom_range(0, 4))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    3: return '1;
                    default: return W'(1);
                endcase
            end
            VAL_NEAR: return W'(int'($urandom_range(0, 524288)) - 262144);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [W-1:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return pick_word(VAL_NEAR);
        if (r < 9) return pick_word(VAL_ANY);
        return pick_word(VAL_CORNER);
    endfunction

    task automatic set_reg(input logic [pcfd_pkg::REG_IDX_W-1:0] idx,
                           input logic [W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            pcfd_pkg::REG_PROP_GAIN: kp = longint'($signed(val));
            pcfd_pkg::REG_INTEG_GAIN: ki = longint'($signed(val));
            pcfd_pkg::REG_DERIV_GAIN: kd = longint'($signed(val));
            pcfd_pkg::REG_SMOOTH_FACTOR: alpha_raw = longint'(val[pcfd_pkg::ALPHA_W-1:0]);
            pcfd_pkg::REG_DRIVE_MIN: lim_lo = longint'($signed(val));
            pcfd_pkg::REG_DRIVE_MAX: lim_hi = longint'($signed(val));
            pcfd_pkg::REG_SETPOINT: target = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [W-1:0] p, input logic [W-1:0] i,
                                  input logic [W-1:0] d, input logic [W-1:0] a,
                                  input logic [W-1:0] lo, input logic [W-1:0] hi,
                                  input logic [W-1:0] sp);
        set_reg(pcfd_pkg::REG_PROP_GAIN, p);
        set_reg(pcfd_pkg::REG_INTEG_GAIN, i);
        set_reg(pcfd_pkg::REG_DERIV_GAIN, d);
        set_reg(pcfd_pkg::REG_SMOOTH_FACTOR, a);
        set_reg(pcfd_pkg::REG_DRIVE_MIN, lo);
        set_reg(pcfd_pkg::REG_DRIVE_MAX, hi);
        set_reg(pcfd_pkg::REG_SETPOINT, sp);
        settings_count++;
    endtask

    task automatic random_settings();
        logic [W-1:0] lo_w, hi_w, tmp, a_w;
        lo_w = random_word();
        hi_w = random_word();
        // keep the limits in order most of the time
        if ($signed(lo_w) > $signed(hi_w) && $urandom_range(0, 5) != 0)
        begin
            tmp = lo_w;
            lo_w = hi_w;
            hi_w = tmp;
        end
        case ($urandom_range(0, 4))
            0: a_w = '0;
            1: a_w = W'(UNITY);
            4: a_w = $urandom();
            default: a_w = W'($urandom_range(0, 65536));
        endcase
        apply_settings(random_word(), random_word(), random_word(), a_w,
                       lo_w, hi_w, random_word());
        if ($urandom_range(0, 2) == 0)
            set_reg(REG_SPARE, $urandom());
    endtask

    task automatic enqueue(input logic [W-1:0] v);
        sample_queue.push_back(v);
        queued_count++;
    endtask

    // mostly a slow drift around the target, with jumps, noise and corners
    task automatic queue_samples(input int count);
        longint level;
        int unsigned kind;
        level = target;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                level = sat_w(level + int'($urandom_range(0, 16384)) - 8192);
                enqueue(W'(level));
            end
            else if (kind < 15)
            begin
                level = sat_w(target + int'($urandom_range(0, 524288)) - 262144);
                enqueue(W'(level));
            end
            else if (kind < 18)
                enqueue(pick_word(VAL_ANY));
            else
                enqueue(pick_word(VAL_CORNER));
        end
    endtask

    task automatic settle();
        while (accepted_count != queued_count || drive_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && (!drv_valid || sample_ch.ready))
        begin
            if (gap_left > 0)
            begin
                drv_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (sample_queue.size() > 0)
            begin
                drv_valid <= 1'b1;
                drv_meas <= sample_queue.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int rx_tick = 0;

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (holds_done != holds_asked)
        begin
            holds_done <= holds_asked;
            hold_left <= LONG_HOLD;
            rcv_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rcv_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 160);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: rcv_ready <= 1'b1;
                1: rcv_ready <= ($urandom_range(0, 1) == 1);
                2: rcv_ready <= (rx_tick % 4 != 3);
                default: rcv_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : drive_check
        logic [W-1:0] want;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                drive_queue.push_back(next_drive(sample_ch.measured));
                accepted_count++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                result_count++;
                if (drive_queue.size() == 0)
                begin
                    $error("drive: no request pending, actual %0d", $signed(result_ch.drive));
                    fail_count++;
                end
                else
                begin
                    want = drive_queue.pop_front();
                    if (result_ch.drive !== want)
                    begin
                        $error("drive: expected %0d, actual %0d",
                               $signed(want), $signed(result_ch.drive));
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, drive_queue.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // moderate loop: windup ramp at the start, then slope saturation
        apply_settings(32'h0001_0000, 32'h0000_2000, 32'h0000_8000, 32'h0000_4000,
                       32'hFFCE_0000, 32'h0032_0000, 32'h000A_0000);
        set_reg(REG_SPARE, '1);
        enqueue('0);
        enqueue('0);
        enqueue('0);
        enqueue(32'h000A_0000);
        enqueue(32'h0014_0000);
        enqueue(WORD_MAX);
        enqueue(WORD_MIN);
        enqueue(WORD_MAX);
        enqueue('1);
        enqueue(W'(1));
        settle();

        // largest gains, unity filter, widest limits
        apply_settings(WORD_MAX, WORD_MAX, WORD_MAX, W'(UNITY), WORD_MIN, WORD_MAX, WORD_MIN);
        enqueue(WORD_MAX);
        enqueue(WORD_MIN);
        enqueue('0);
        enqueue(WORD_MAX);
        settle();

        // most negative gains, filter factor above one, inverted limits
        apply_settings(WORD_MIN, WORD_MIN, WORD_MIN, '1, 32'h0005_0000, 32'hFFFB_0000,
                       WORD_MAX);
        enqueue(WORD_MIN);
        enqueue(WORD_MAX);
        enqueue('0);
        enqueue(32'h0005_0000);
        enqueue(32'hFFFB_0000);
        settle();

        // everything off, limits pinned at zero
        apply_settings('0, '0, '0, '0, '0, '0, '0);
        enqueue('1);
        enqueue(WORD_MIN);
        settle();

        for (int ph = 0; ph < 9; ph++)
        begin
            random_settings();
            queue_samples(52);
            // back up the output while the input keeps offering
            if (ph == 2)
                holds_asked++;
            settle();
            queue_samples(51);
            settle();
        end

        repeat (SETTLE) @(posedge clk);
        $display("Checked %0d drive results across %0d controller settings,",
                 result_count, settings_count);
        $display("including saturating gains, inverted limits and %0d long output stalls.",
                 holds_asked);
        if (fail_count == 0 && drive_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
